### hdl/sbcc_pkg.sv
// Shared constants and types for the segment/box collision check unit.
// Used by the top level, the front end and the back end; depends on nothing else.
`timescale 1ns / 1ps

package sbcc_pkg;

  // Default sizes of the block.
  localparam int unsigned MaxObstacles    = 64;
  localparam int unsigned SampleDivisions = 32;
  localparam int unsigned CoordBits       = 12;

  // Clearance register.
  localparam int unsigned MarginBits  = 8;
  localparam logic [MarginBits-1:0] MarginReset = 8'd10;
  localparam int unsigned ApbDataBits = 32;
  localparam int unsigned ApbAddrBits = 3;
  localparam logic RegIdxMargin = 1'b0;

  // Item kinds as they arrive on the input channel.
  typedef enum logic [1:0] {
    OP_ADD     = 2'd0,
    OP_CLEAR   = 2'd1,
    OP_POINT   = 2'd2,
    OP_SEGMENT = 2'd3
  } sbcc_op_e;

endpackage

### hdl/segment_box_collision_check_unit.sv
// Top level of the segment/box collision check unit: ports, clearance register, wiring.
// Depends on sbcc_pkg, sbcc_front, sbcc_fifo and sbcc_back.
`timescale 1ns / 1ps

// Usage:
// Items enter on the input channel (in_valid_i/in_ready_o) with a kind and two
// coordinate pairs: insert an obstacle, clear the table, query a point, or query a
// segment. Each item produces exactly one result on the output channel
// (out_valid_o/out_ready_i): is_free, dropped and the obstacle count after the item.
// The clearance is written over the APB port at byte address 0, by the user only
// while idle; the block does not enforce it. A two-entry queue decouples the input
// from the back end, so new items are taken while a result waits for its receiver;
// when the receiver stalls, the result register holds and the queue fills, after
// which in_ready_o drops. An insert or clear passes through the finish state into
// the result register, and the back end takes the next item once it is loaded.
// A point or segment query walks the stored obstacles before its result is loaded,
// and the back end takes no new item until then: it reads one obstacle per cycle
// from the table memory, and all interior samples are compared against it in
// parallel; that walk sets the throughput.
// Reset empties the table count and the queue, sets the clearance to 10, and leaves
// the table contents undefined; no clearing pass is needed.

module segment_box_collision_check_unit #(
  parameter int unsigned MAX_OBSTACLES    = sbcc_pkg::MaxObstacles,
  parameter int unsigned SAMPLE_DIVISIONS = sbcc_pkg::SampleDivisions,
  parameter int unsigned COORD_BITS       = sbcc_pkg::CoordBits,
  localparam int unsigned CntBits = $clog2(MAX_OBSTACLES + 1)
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_ready_o,
  input  logic [1:0]                         kind_i,
  input  logic [COORD_BITS-1:0]              first_x_i,
  input  logic [COORD_BITS-1:0]              first_y_i,
  input  logic [COORD_BITS-1:0]              second_x_i,
  input  logic [COORD_BITS-1:0]              second_y_i,
  output logic                               out_valid_o,
  input  logic                               out_ready_i,
  output logic                               is_free_o,
  output logic                               dropped_o,
  output logic [CntBits-1:0]                 obstacle_count_o,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [sbcc_pkg::ApbAddrBits-1:0]   paddr,
  input  logic [sbcc_pkg::ApbDataBits-1:0]   pwdata,
  output logic [sbcc_pkg::ApbDataBits-1:0]   prdata,
  output logic                               pready
);
  import sbcc_pkg::*;

  localparam int unsigned ItemBits = 2 + 4 * COORD_BITS + 2 * (COORD_BITS + 1);

  logic [MarginBits-1:0] margin_q;
  logic                  cfg_wr;

  sbcc_op_e                   f_op, b_op;
  logic [COORD_BITS-1:0]      f_fx, f_fy, f_sx, f_sy;
  logic [COORD_BITS-1:0]      b_fx, b_fy, b_sx, b_sy;
  logic signed [COORD_BITS:0] f_dx, f_dy, b_dx, b_dy;
  logic                       push_valid, push_ready, pop_valid, pop_ready;
  logic [ItemBits-1:0]        push_data, pop_data;

  // Configuration port: a write transfer lands on the clearance register.
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == RegIdxMargin);
  assign prdata = (paddr[2] == RegIdxMargin) ? ApbDataBits'(margin_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      margin_q <= MarginReset;
    end else if (cfg_wr) begin
      margin_q <= pwdata[MarginBits-1:0];
    end
  end

  sbcc_front #(
    .COORD_BITS (COORD_BITS)
  ) u_front (
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .first_x_i    (first_x_i),
    .first_y_i    (first_y_i),
    .second_x_i   (second_x_i),
    .second_y_i   (second_y_i),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .op_o         (f_op),
    .first_x_o    (f_fx),
    .first_y_o    (f_fy),
    .second_x_o   (f_sx),
    .second_y_o   (f_sy),
    .delta_x_o    (f_dx),
    .delta_y_o    (f_dy)
  );

  // Pack the classified item for the queue and unpack it on the far side.
  assign push_data = {f_op, f_fx, f_fy, f_sx, f_sy, f_dx, f_dy};

  sbcc_fifo #(
    .WIDTH (ItemBits)
  ) u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_data_i  (push_data),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_data_o   (pop_data)
  );

  always_comb begin
    b_op = sbcc_op_e'(pop_data[ItemBits-1 -: 2]);
    b_fx = pop_data[ItemBits-3 -: COORD_BITS];
    b_fy = pop_data[ItemBits-3-COORD_BITS -: COORD_BITS];
    b_sx = pop_data[ItemBits-3-2*COORD_BITS -: COORD_BITS];
    b_sy = pop_data[ItemBits-3-3*COORD_BITS -: COORD_BITS];
    b_dx = $signed(pop_data[2*COORD_BITS+1 -: COORD_BITS+1]);
    b_dy = $signed(pop_data[COORD_BITS:0]);
  end

  sbcc_back #(
    .MAX_OBSTACLES    (MAX_OBSTACLES),
    .SAMPLE_DIVISIONS (SAMPLE_DIVISIONS),
    .COORD_BITS       (COORD_BITS)
  ) u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .item_valid_i     (pop_valid),
    .item_ready_o     (pop_ready),
    .op_i             (b_op),
    .first_x_i        (b_fx),
    .first_y_i        (b_fy),
    .second_x_i       (b_sx),
    .second_y_i       (b_sy),
    .delta_x_i        (b_dx),
    .delta_y_i        (b_dy),
    .margin_i         (margin_q),
    .out_valid_o      (out_valid_o),
    .out_ready_i      (out_ready_i),
    .is_free_o        (is_free_o),
    .dropped_o        (dropped_o),
    .obstacle_count_o (obstacle_count_o)
  );

endmodule

### hdl/sbcc_front.sv
// Front end: takes input items and classifies them for the back end.
// Depends on sbcc_pkg for the item kinds.
`timescale 1ns / 1ps

module sbcc_front #(
  parameter int unsigned COORD_BITS = sbcc_pkg::CoordBits
) (
  input  logic                         in_valid_i,
  output logic                         in_ready_o,
  input  logic [1:0]                   kind_i,
  input  logic [COORD_BITS-1:0]        first_x_i,
  input  logic [COORD_BITS-1:0]        first_y_i,
  input  logic [COORD_BITS-1:0]        second_x_i,
  input  logic [COORD_BITS-1:0]        second_y_i,
  output logic                         push_valid_o,
  input  logic                         push_ready_i,
  output sbcc_pkg::sbcc_op_e           op_o,
  output logic [COORD_BITS-1:0]        first_x_o,
  output logic [COORD_BITS-1:0]        first_y_o,
  output logic [COORD_BITS-1:0]        second_x_o,
  output logic [COORD_BITS-1:0]        second_y_o,
  output logic signed [COORD_BITS:0]   delta_x_o,
  output logic signed [COORD_BITS:0]   delta_y_o
);
  import sbcc_pkg::*;

  sbcc_op_e op;
  logic     seg;

  // The front end stalls only when the queue is full.
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  // Decode the kind; a point query becomes a segment whose samples all coincide.
  always_comb begin
    op  = sbcc_op_e'(kind_i);
    seg = (op == OP_SEGMENT);
  end

  assign op_o       = op;
  assign first_x_o  = first_x_i;
  assign first_y_o  = first_y_i;
  assign second_x_o = second_x_i;
  assign second_y_o = second_y_i;

  // Per-step displacement of the sample points, zero for a point query.
  assign delta_x_o = seg ? ($signed({1'b0, second_x_i}) - $signed({1'b0, first_x_i}))
                         : '0;
  assign delta_y_o = seg ? ($signed({1'b0, second_y_i}) - $signed({1'b0, first_y_i}))
                         : '0;

endmodule

### hdl/sbcc_fifo.sv
// Two-entry queue between the front and back ends.
// Generic data width; no package dependency beyond the house style.
`timescale 1ns / 1ps

module sbcc_fifo #(
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_valid_i,
  output logic             push_ready_o,
  input  logic [WIDTH-1:0] push_data_i,
  output logic             pop_valid_o,
  input  logic             pop_ready_i,
  output logic [WIDTH-1:0] pop_data_o
);

  logic [WIDTH-1:0] entry_q [2];
  logic             wr_ptr_q, wr_ptr_d;
  logic             rd_ptr_q, rd_ptr_d;
  logic [1:0]       fill_q, fill_d;
  logic             push, pop;

  assign push_ready_o = (fill_q != 2'd2);
  assign pop_valid_o  = (fill_q != 2'd0);
  assign pop_data_o   = entry_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_ready_i && pop_valid_o;

  // Pointer and fill bookkeeping.
  always_comb begin
    wr_ptr_d = push ? ~wr_ptr_q : wr_ptr_q;
    rd_ptr_d = pop ? ~rd_ptr_q : rd_ptr_q;
    fill_d   = fill_q + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      fill_q   <= 2'd0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      fill_q   <= fill_d;
    end
  end

  // Entry storage needs no reset.
  always_ff @(posedge clk_i) begin
    if (push) begin
      entry_q[wr_ptr_q] <= push_data_i;
    end
  end

endmodule

### hdl/sbcc_back.sv
// Back end: obstacle table, obstacle walk with parallel sample compare, result register.
// Depends on sbcc_pkg for the item kinds and the clearance width.
`timescale 1ns / 1ps

module sbcc_back #(
  parameter int unsigned MAX_OBSTACLES    = sbcc_pkg::MaxObstacles,
  parameter int unsigned SAMPLE_DIVISIONS = sbcc_pkg::SampleDivisions,
  parameter int unsigned COORD_BITS       = sbcc_pkg::CoordBits,
  localparam int unsigned CntBits = $clog2(MAX_OBSTACLES + 1)
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                item_valid_i,
  output logic                                item_ready_o,
  input  sbcc_pkg::sbcc_op_e                  op_i,
  input  logic [COORD_BITS-1:0]               first_x_i,
  input  logic [COORD_BITS-1:0]               first_y_i,
  input  logic [COORD_BITS-1:0]               second_x_i,
  input  logic [COORD_BITS-1:0]               second_y_i,
  input  logic signed [COORD_BITS:0]          delta_x_i,
  input  logic signed [COORD_BITS:0]          delta_y_i,
  input  logic [sbcc_pkg::MarginBits-1:0]     margin_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic                                is_free_o,
  output logic                                dropped_o,
  output logic [CntBits-1:0]                  obstacle_count_o
);
  import sbcc_pkg::*;

  localparam int unsigned AddrBits = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;
  localparam int unsigned NumSamples = SAMPLE_DIVISIONS - 1;
  // Scaled coordinates and grown bounds, signed, with headroom for the margin.
  localparam int unsigned SW = COORD_BITS + $clog2(SAMPLE_DIVISIONS) + 3;
  localparam int unsigned EntryBits = 4 * COORD_BITS;
  localparam logic [CntBits-1:0] MaxCount = CntBits'(MAX_OBSTACLES);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_LOAD   = 5'b00010,
    ST_WALK   = 5'b00100,
    ST_DRAIN  = 5'b01000,
    ST_FINISH = 5'b10000
  } sbcc_state_e;

  sbcc_state_e state_q, state_d;
  logic [CntBits-1:0] count_q, count_d;
  logic [CntBits-1:0] idx_q, idx_d;
  logic               res_free_q, res_free_d;
  logic               res_drop_q, res_drop_d;
  logic               out_valid_q, out_valid_d;
  logic               out_free_q, out_drop_q;
  logic [CntBits-1:0] out_count_q;

  // Query operands held for the sample build.
  logic [COORD_BITS-1:0]      qx_q, qy_q;
  logic signed [COORD_BITS:0] qdx_q, qdy_q;

  // Sample points and the obstacle pipeline.
  logic signed [SW-1:0] smp_x_q [NumSamples];
  logic signed [SW-1:0] smp_y_q [NumSamples];
  logic [EntryBits-1:0] table_mem [MAX_OBSTACLES];
  logic [EntryBits-1:0] rd_data_q;
  logic                 rd_v_q, bnd_v_q;
  logic signed [SW-1:0] lo_x_q, hi_x_q, lo_y_q, hi_y_q;
  logic                 hit_q, hit_d;
  logic                 any_hit;

  logic pop, mem_we, rd_en, load_out;

  assign item_ready_o = (state_q == ST_IDLE);
  assign pop          = item_valid_i && item_ready_o;
  assign load_out     = (state_q == ST_FINISH) && (!out_valid_q || out_ready_i);

  // Control sequencer: one item at a time.
  always_comb begin
    state_d     = state_q;
    count_d     = count_q;
    idx_d       = idx_q;
    res_free_d  = res_free_q;
    res_drop_d  = res_drop_q;
    hit_d       = hit_q;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    out_valid_d = out_valid_q;
    if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
    if (bnd_v_q && any_hit) begin
      hit_d = 1'b1;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (pop) begin
          res_free_d = 1'b0;
          res_drop_d = 1'b0;
          unique case (op_i)
            OP_ADD: begin
              if (count_q < MaxCount) begin
                mem_we  = 1'b1;
                count_d = count_q + 1'b1;
              end else begin
                res_drop_d = 1'b1;
              end
              state_d = ST_FINISH;
            end
            OP_CLEAR: begin
              count_d = '0;
              state_d = ST_FINISH;
            end
            OP_POINT, OP_SEGMENT: begin
              state_d = ST_LOAD;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_LOAD: begin
        idx_d   = '0;
        hit_d   = 1'b0;
        state_d = ST_WALK;
      end
      ST_WALK: begin
        if (idx_q < count_q) begin
          rd_en = 1'b1;
          idx_d = idx_q + 1'b1;
        end else begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (!rd_v_q && !bnd_v_q) begin
          res_free_d = !hit_q;
          state_d    = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (load_out) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      idx_q       <= '0;
      res_free_q  <= 1'b0;
      res_drop_q  <= 1'b0;
      hit_q       <= 1'b0;
      out_valid_q <= 1'b0;
      rd_v_q      <= 1'b0;
      bnd_v_q     <= 1'b0;
    end else begin
      state_q     <= state_d;
      count_q     <= count_d;
      idx_q       <= idx_d;
      res_free_q  <= res_free_d;
      res_drop_q  <= res_drop_d;
      hit_q       <= hit_d;
      out_valid_q <= out_valid_d;
      rd_v_q      <= rd_en;
      bnd_v_q     <= rd_v_q;
    end
  end

  // Result register, loaded once the previous result has been taken.
  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_free_q  <= res_free_q;
      out_drop_q  <= res_drop_q;
      out_count_q <= count_q;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign is_free_o        = out_free_q;
  assign dropped_o        = out_drop_q;
  assign obstacle_count_o = out_count_q;

  // Obstacle table: one write port for inserts, one registered read port for the walk.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      table_mem[count_q[AddrBits-1:0]] <= {first_x_i, first_y_i, second_x_i, second_y_i};
    end
    if (rd_en) begin
      rd_data_q <= table_mem[idx_q[AddrBits-1:0]];
    end
  end

  // Capture the query operands when it leaves the queue.
  always_ff @(posedge clk_i) begin
    if (pop) begin
      qx_q  <= first_x_i;
      qy_q  <= first_y_i;
      qdx_q <= delta_x_i;
      qdy_q <= delta_y_i;
    end
  end

  // Build all interior sample points, exact in units of one division.
  always_ff @(posedge clk_i) begin
    if (state_q == ST_LOAD) begin
      for (int k = 1; k < SAMPLE_DIVISIONS; k++) begin
        smp_x_q[k-1] <= $signed(SW'(qx_q)) * $signed(SW'(SAMPLE_DIVISIONS))
                        + $signed(SW'(qdx_q)) * $signed(SW'(k));
        smp_y_q[k-1] <= $signed(SW'(qy_q)) * $signed(SW'(SAMPLE_DIVISIONS))
                        + $signed(SW'(qdy_q)) * $signed(SW'(k));
      end
    end
  end

  // Grow the fetched obstacle by the clearance and scale its bounds.
  always_ff @(posedge clk_i) begin
    logic signed [SW-1:0] left, top, wid, hgt, mar, div;
    left = $signed(SW'(rd_data_q[4*COORD_BITS-1:3*COORD_BITS]));
    top  = $signed(SW'(rd_data_q[3*COORD_BITS-1:2*COORD_BITS]));
    wid  = $signed(SW'(rd_data_q[2*COORD_BITS-1:COORD_BITS]));
    hgt  = $signed(SW'(rd_data_q[COORD_BITS-1:0]));
    mar  = $signed(SW'(margin_i));
    div  = $signed(SW'(SAMPLE_DIVISIONS));
    if (rd_v_q) begin
      lo_x_q <= (left - mar) * div;
      hi_x_q <= (left + wid + mar) * div;
      lo_y_q <= (top - mar) * div;
      hi_y_q <= (top + hgt + mar) * div;
    end
  end

  // Compare every sample against the grown obstacle, boundary counted as inside.
  always_comb begin
    any_hit = 1'b0;
    for (int k = 0; k < NumSamples; k++) begin
      if (smp_x_q[k] >= lo_x_q && smp_x_q[k] <= hi_x_q &&
          smp_y_q[k] >= lo_y_q && smp_y_q[k] <= hi_y_q) begin
        any_hit = 1'b1;
      end
    end
  end

endmodule
